### design/mrs_pkg.sv
// Shared constants, types and the CRC helper of the Modbus RTU register server.
package mrs_pkg;

    // Sizes of the register file and of the frame buffer.
    localparam int NUM_REGS    = 16;
    localparam int FRAME_BYTES = 64;
    localparam int RIDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int FIDX_W      = $clog2(FRAME_BYTES);
    localparam int LEN_W       = FIDX_W + 1;
    localparam int MAX_READ    = 16;
    localparam int K_W         = 6;

    // CRC-16 settings.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Reset values of the configuration registers.
    localparam logic [7:0] ADDR_RESET    = 8'd41;
    localparam logic [7:0] SILENCE_RESET = 8'd28;

    // Configuration register indexes.
    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_SILENCE_TICKS = 1'b1;

    // Input item kinds.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Function codes.
    localparam logic [7:0] FN_READ_HOLDING = 8'd3;
    localparam logic [7:0] FN_READ_ONE     = 8'd4;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
    localparam logic [7:0] FN_WRITE_MULTI  = 8'd16;

    // Request kinds as held inside the block.
    localparam logic [1:0] KIND_RD3  = 2'd0;
    localparam logic [1:0] KIND_RD4  = 2'd1;
    localparam logic [1:0] KIND_WR6  = 2'd2;
    localparam logic [1:0] KIND_WR16 = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic clear;
        logic reply_start;
        logic write6;
        logic sweep_start;
        logic sweep;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       close_hit;
        logic       kind_ok;
        logic [1:0] kind;
        logic       sweep_done;
        logic       out_free;
        logic       emit_last;
    } stat_t;

    // One byte of the reflected CRC-16.
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### design/mrs_ctrl.sv
// Controller state machine of the Modbus RTU register server.
module mrs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  mrs_pkg::stat_t stat,
    output mrs_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_REPLY = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.close_hit)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!stat.kind_ok)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.reply_start = 1'b1;
                    cmd.write6      = (stat.kind == mrs_pkg::KIND_WR6);
                    cmd.sweep_start = (stat.kind == mrs_pkg::KIND_WR16);
                    state_next = (stat.kind == mrs_pkg::KIND_WR16) ? ST_SWEEP : ST_REPLY;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                    state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A reply is only started from a checked request.
    a_start_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reply_start |-> $past(state_reg) == ST_IDLE)
        else $error("reply started without a closing tick");
    // Bytes are only taken while idle.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !cmd.emit && !cmd.sweep)
        else $error("input taken while busy");
    // Leaving the sweep means the sweep finished.
    a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && state_next == ST_REPLY) |-> stat.sweep_done)
        else $error("sweep left early");

endmodule

### design/mrs_datapath.sv
// Datapath of the Modbus RTU register server: frame buffer, register file, CRC and reply.
module mrs_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           in_acc,
    input  logic           in_opcode,
    input  logic [7:0]     in_byte,
    input  mrs_pkg::cmd_t  cmd,
    output mrs_pkg::stat_t stat,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    logic [7:0]                  addr_cfg_reg;
    logic [7:0]                  silence_reg;
    logic                        in_frame_reg;
    logic [mrs_pkg::LEN_W-1:0]   len_reg;
    logic                        ovf_reg;
    logic [7:0]                  idle_reg;
    logic [7:0]                  hdr_reg [0:6];
    logic [7:0]                  tail1_reg;
    logic [7:0]                  tail2_reg;
    logic [15:0]                 fcrc_reg;
    logic [7:0]                  mem [0:mrs_pkg::FRAME_BYTES-1];
    logic [15:0]                 regs_reg [0:mrs_pkg::NUM_REGS-1];
    logic [1:0]                  kind_reg;
    logic [mrs_pkg::LEN_W-1:0]   ptr_reg;
    logic                        pend_reg;
    logic                        low_reg;
    logic [7:0]                  hi_reg;
    logic [7:0]                  rdata_reg;
    logic [mrs_pkg::RIDX_W-1:0]  widx_reg;
    logic [mrs_pkg::K_W-1:0]     k_reg;
    logic [15:0]                 rcrc_reg;
    logic [mrs_pkg::RIDX_W-1:0]  rptr_reg;
    logic                        out_valid_reg;
    logic [7:0]                  out_data_reg;
    logic                        out_last_reg;

    logic [7:0]  idle_inc;
    logic        store_byte;
    logic        open_frame;
    logic [15:0] a16;
    logic [15:0] c16;
    logic [16:0] a_plus_c;
    logic [17:0] len16;
    logic        crc_ok;
    logic        base_ok;
    logic        range_ok;
    logic        len8;
    logic [1:0]  kind;
    logic        kind_ok;
    logic        issue;
    logic [mrs_pkg::K_W-1:0] ndata;
    logic [15:0] rv;
    logic [7:0]  reg_byte;
    logic [7:0]  data_byte;
    logic [7:0]  emit_byte;
    logic        emit_last;

    // Byte and tick decoding.
    assign idle_inc   = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
    assign store_byte = in_acc && (in_opcode == mrs_pkg::OP_BYTE) && in_frame_reg
                        && (len_reg < mrs_pkg::LEN_W'(mrs_pkg::FRAME_BYTES));
    assign open_frame = in_acc && (in_opcode == mrs_pkg::OP_BYTE) && !in_frame_reg
                        && (in_byte == addr_cfg_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_cfg_reg <= mrs_pkg::ADDR_RESET;
            silence_reg  <= mrs_pkg::SILENCE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mrs_pkg::CFG_SLAVE_ADDRESS)
                addr_cfg_reg <= cfg_data;
            else
                silence_reg <= cfg_data;
        end
    end

    // Frame control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            idle_reg     <= '0;
        end
        else if (cmd.clear)
        begin
            in_frame_reg <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            idle_reg     <= '0;
        end
        else if (open_frame)
        begin
            in_frame_reg <= 1'b1;
            len_reg      <= mrs_pkg::LEN_W'(1);
            ovf_reg      <= 1'b0;
            idle_reg     <= '0;
        end
        else if (in_acc && in_frame_reg)
        begin
            if (in_opcode == mrs_pkg::OP_BYTE)
            begin
                idle_reg <= '0;
                if (store_byte)
                    len_reg <= len_reg + mrs_pkg::LEN_W'(1);
                else
                    ovf_reg <= 1'b1;
            end
            else
            begin
                idle_reg <= idle_inc;
            end
        end
    end

    // Frame payload: header copy, last two bytes and the running CRC that lags by two bytes.
    always_ff @(posedge clk)
    begin
        if (open_frame)
        begin
            hdr_reg[0] <= in_byte;
            tail1_reg  <= in_byte;
            fcrc_reg   <= mrs_pkg::CRC_INIT;
            mem[0]     <= in_byte;
        end
        else if (store_byte)
        begin
            mem[len_reg[mrs_pkg::FIDX_W-1:0]] <= in_byte;
            if (len_reg < mrs_pkg::LEN_W'(7))
                hdr_reg[len_reg[2:0]] <= in_byte;
            if (len_reg >= mrs_pkg::LEN_W'(2))
                fcrc_reg <= mrs_pkg::crc_update(fcrc_reg, tail2_reg);
            tail2_reg <= tail1_reg;
            tail1_reg <= in_byte;
        end
        if (issue)
            rdata_reg <= mem[ptr_reg[mrs_pkg::FIDX_W-1:0]];
        if (pend_reg && !low_reg)
            hi_reg <= rdata_reg;
    end

    // Request check.
    assign a16      = {hdr_reg[2], hdr_reg[3]};
    assign c16      = {hdr_reg[4], hdr_reg[5]};
    assign a_plus_c = {1'b0, a16} + {1'b0, c16};
    assign len16    = {1'b0, c16, 1'b0} + 18'd9;
    assign crc_ok   = ({tail1_reg, tail2_reg} == fcrc_reg);
    assign base_ok  = !ovf_reg && (len_reg >= mrs_pkg::LEN_W'(8)) && crc_ok;
    assign range_ok = (a_plus_c <= 17'(mrs_pkg::NUM_REGS));
    assign len8     = (len_reg == mrs_pkg::LEN_W'(8));

    always_comb
    begin
        kind    = mrs_pkg::KIND_RD3;
        kind_ok = 1'b0;
        case (hdr_reg[1])
            mrs_pkg::FN_READ_HOLDING:
            begin
                kind    = mrs_pkg::KIND_RD3;
                kind_ok = len8 && (c16 != 16'd0) && (c16 <= 16'(mrs_pkg::MAX_READ)) && range_ok;
            end
            mrs_pkg::FN_READ_ONE:
            begin
                kind    = mrs_pkg::KIND_RD4;
                kind_ok = len8 && (a16 < 16'(mrs_pkg::NUM_REGS));
            end
            mrs_pkg::FN_WRITE_SINGLE:
            begin
                kind    = mrs_pkg::KIND_WR6;
                kind_ok = len8 && (a16 < 16'(mrs_pkg::NUM_REGS));
            end
            mrs_pkg::FN_WRITE_MULTI:
            begin
                kind    = mrs_pkg::KIND_WR16;
                kind_ok = (c16 != 16'd0) && range_ok && (c16 <= 16'd127)
                          && (hdr_reg[6] == {c16[6:0], 1'b0})
                          && (len16 == 18'(len_reg));
            end
            default:
            begin
                kind    = mrs_pkg::KIND_RD3;
                kind_ok = 1'b0;
            end
        endcase
    end

    // Write sweep over the data bytes of a multiple write.
    assign issue = cmd.sweep && ({1'b0, ptr_reg} + (mrs_pkg::LEN_W + 1)'(3) <= {1'b0, len_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
            low_reg  <= 1'b0;
            widx_reg <= '0;
            for (int i = 0; i < mrs_pkg::NUM_REGS; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            if (cmd.sweep_start)
            begin
                ptr_reg  <= mrs_pkg::LEN_W'(7);
                pend_reg <= 1'b0;
                widx_reg <= a16[mrs_pkg::RIDX_W-1:0];
            end
            else
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    ptr_reg <= ptr_reg + mrs_pkg::LEN_W'(1);
                    low_reg <= !ptr_reg[0];
                end
                if (pend_reg && low_reg)
                begin
                    regs_reg[widx_reg] <= {hi_reg, rdata_reg};
                    widx_reg <= widx_reg + mrs_pkg::RIDX_W'(1);
                end
            end
            if (cmd.write6)
                regs_reg[a16[mrs_pkg::RIDX_W-1:0]] <= c16;
        end
    end

    // Reply byte selection.
    always_comb
    begin
        case (kind_reg)
            mrs_pkg::KIND_RD3: ndata = mrs_pkg::K_W'(3) + {c16[mrs_pkg::K_W-2:0], 1'b0};
            mrs_pkg::KIND_RD4: ndata = mrs_pkg::K_W'(5);
            default:           ndata = mrs_pkg::K_W'(6);
        endcase
    end

    assign rv       = regs_reg[rptr_reg];
    assign reg_byte = k_reg[0] ? rv[15:8] : rv[7:0];

    always_comb
    begin
        case (k_reg)
            mrs_pkg::K_W'(0): data_byte = hdr_reg[0];
            mrs_pkg::K_W'(1): data_byte = hdr_reg[1];
            mrs_pkg::K_W'(2):
            begin
                if (kind_reg == mrs_pkg::KIND_RD3)
                    data_byte = {c16[6:0], 1'b0};
                else if (kind_reg == mrs_pkg::KIND_RD4)
                    data_byte = 8'd2;
                else
                    data_byte = hdr_reg[2];
            end
            mrs_pkg::K_W'(3):
                data_byte = (kind_reg == mrs_pkg::KIND_RD3 || kind_reg == mrs_pkg::KIND_RD4)
                            ? reg_byte : hdr_reg[3];
            mrs_pkg::K_W'(4):
                data_byte = (kind_reg == mrs_pkg::KIND_RD3 || kind_reg == mrs_pkg::KIND_RD4)
                            ? reg_byte : hdr_reg[4];
            mrs_pkg::K_W'(5):
                data_byte = (kind_reg == mrs_pkg::KIND_RD3) ? reg_byte : hdr_reg[5];
            default: data_byte = reg_byte;
        endcase
    end

    assign emit_last = (k_reg == ndata + mrs_pkg::K_W'(1));
    assign emit_byte = (k_reg < ndata) ? data_byte
                     : (k_reg == ndata) ? rcrc_reg[7:0] : rcrc_reg[15:8];

    // Reply sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= mrs_pkg::KIND_RD3;
            k_reg    <= '0;
            rptr_reg <= '0;
            rcrc_reg <= mrs_pkg::CRC_INIT;
        end
        else if (cmd.reply_start)
        begin
            kind_reg <= kind;
            k_reg    <= '0;
            rptr_reg <= a16[mrs_pkg::RIDX_W-1:0];
            rcrc_reg <= mrs_pkg::CRC_INIT;
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + mrs_pkg::K_W'(1);
            if (k_reg < ndata)
                rcrc_reg <= mrs_pkg::crc_update(rcrc_reg, data_byte);
            if (k_reg >= mrs_pkg::K_W'(4) && !k_reg[0])
                rptr_reg <= rptr_reg + mrs_pkg::RIDX_W'(1);
        end
    end

    // Output register, so a reply byte can wait while the next item arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller.
    assign stat.close_hit  = in_acc && (in_opcode == mrs_pkg::OP_TICK) && in_frame_reg
                             && (idle_inc >= silence_reg);
    assign stat.kind_ok    = base_ok && kind_ok;
    assign stat.kind       = kind;
    assign stat.sweep_done = !issue && !pend_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.emit_last  = emit_last;

    // A byte is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("reply byte overwrote a waiting byte");
    // The frame length never passes the buffer size.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= mrs_pkg::LEN_W'(mrs_pkg::FRAME_BYTES))
        else $error("frame length out of range");
    // The final CRC byte appears flagged as last.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && emit_last) |=> (out_valid_reg && out_last_reg))
        else $error("last reply byte not flagged");

endmodule

### design/modbus_rtu_slave_register_server_unit.sv
// Top level of the Modbus RTU slave register server.
// The tick that closes a frame starts a reply sequence: a check of the request, for a multiple
// write a sweep through the frame buffer (one byte per cycle from its single read port), then
// the reply bytes (at most 37) while the output side takes them. No new item is taken until
// the last reply byte sits in the output register. The frame buffer needs no clearing after
// reset.
module modbus_rtu_slave_register_server_unit (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    input  logic       s_tuser,    // [0] opcode
    // Output stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] tx_byte
    output logic       m_tlast
);

    mrs_pkg::cmd_t  cmd;
    mrs_pkg::stat_t stat;
    logic           in_acc;

    // Configuration writes are taken at once.
    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.ready;
    assign in_acc    = s_tvalid && cmd.ready;

    mrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_acc    (in_acc),
        .in_opcode (s_tuser),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
